// ----- hw/rtl/irpd_pkg.sv -----
// Package for the pulse-distance IR frame decoder: widths, reset values,
// status and register codes, and the structs passed between modules.
// Depends on nothing; every other file of the decoder refers to it.
`timescale 1ns / 1ps

package irpd_pkg;

  // Width of a gap as the decoder sees it.
  localparam int unsigned GAP_BITS     = 18;
  localparam int unsigned THR_BITS     = 18;
  localparam int unsigned ADDR_BITS    = 16;
  localparam int unsigned CMD_BITS     = 16;
  localparam int unsigned COUNT_BITS   = 7;
  localparam int unsigned SHIFT_BITS   = ADDR_BITS + CMD_BITS;
  localparam int unsigned TAKEN_BITS   = 6;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 18;

  // Register reset values.
  localparam logic [THR_BITS-1:0]   LEADER_THR_RESET = THR_BITS'(8000);
  localparam logic [THR_BITS-1:0]   ONE_THR_RESET    = THR_BITS'(1700);
  localparam logic [ADDR_BITS-1:0]  ADDR_RESET       = '0;
  localparam logic [COUNT_BITS-1:0] EDGES_RESET      = COUNT_BITS'(50);

  // Number of bits that make up a full frame.
  localparam logic [TAKEN_BITS-1:0] FRAME_BITS = TAKEN_BITS'(SHIFT_BITS);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEADER_THR = 2'd0,
    REG_ONE_THR    = 2'd1,
    REG_EXP_ADDR   = 2'd2,
    REG_EDGES      = 2'd3
  } reg_idx_t;

  // Frame status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_LEADER = 2'd1,
    STATUS_SHORT     = 2'd2,
    STATUS_ADDR_MISS = 2'd3
  } status_t;

  // Configuration as seen by the frame core.
  typedef struct packed {
    logic [THR_BITS-1:0]   leader_thr;
    logic [THR_BITS-1:0]   one_thr;
    logic [ADDR_BITS-1:0]  exp_addr;
    logic [COUNT_BITS-1:0] edges;
  } cfg_t;

  // One decoded frame.
  typedef struct packed {
    status_t              status;
    logic [ADDR_BITS-1:0] address;
    logic [CMD_BITS-1:0]  command;
  } frame_t;

endpackage

// ----- hw/rtl/irpd_gap_if.sv -----
// Valid/ready channel that carries one edge gap into the decoder.
// Depends on irpd_pkg for the gap width.
`timescale 1ns / 1ps

interface irpd_gap_if;
  logic                          valid;
  logic                          ready;
  logic [irpd_pkg::GAP_BITS-1:0] gap_us;

  modport source (output valid, output gap_us, input ready);
  modport sink (input valid, input gap_us, output ready);
endinterface

// ----- hw/rtl/irpd_frame_if.sv -----
// Valid/ready channel that carries one decoded frame out of the decoder.
// Depends on irpd_pkg for the field widths.
`timescale 1ns / 1ps

interface irpd_frame_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     frame_status;
  logic [irpd_pkg::ADDR_BITS-1:0] address_code;
  logic [irpd_pkg::CMD_BITS-1:0]  command_code;

  modport source (output valid, output frame_status, output address_code,
                  output command_code, input ready);
  modport sink (input valid, input frame_status, input address_code,
                input command_code, output ready);
endinterface

// ----- hw/rtl/irpd_frame_core.sv -----
// Frame state of the decoder: gap count, leader flag and bit shifter,
// updated once per step, with the frame verdict worked out alongside.
// Depends on irpd_pkg.
`timescale 1ns / 1ps

module irpd_frame_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [irpd_pkg::GAP_BITS-1:0] gap,
  input  irpd_pkg::cfg_t                cfg,
  output logic                          emit,
  output irpd_pkg::frame_t              frame
);

  logic [irpd_pkg::COUNT_BITS-1:0] gap_counter, gap_counter_next;
  logic                            leader_seen, leader_seen_next;
  logic [irpd_pkg::TAKEN_BITS-1:0] bits_taken, bits_taken_next;
  logic [irpd_pkg::SHIFT_BITS-1:0] bit_shifter, bit_shifter_next;
  logic [irpd_pkg::COUNT_BITS-1:0] target;
  logic [irpd_pkg::ADDR_BITS-1:0]  addr_bits;
  logic                            one_bit;

  // Next frame state for the gap in hand, and the verdict if it ends the frame.
  always_comb begin
    leader_seen_next = leader_seen;
    bits_taken_next  = bits_taken;
    bit_shifter_next = bit_shifter;
    one_bit          = (gap > cfg.one_thr);
    if (!leader_seen) begin
      if (gap > cfg.leader_thr) begin
        leader_seen_next = 1'b1;
      end
    end else if (bits_taken < irpd_pkg::FRAME_BITS) begin
      bit_shifter_next = {bit_shifter[irpd_pkg::SHIFT_BITS-2:0], one_bit};
      bits_taken_next  = bits_taken + 1'b1;
    end

    gap_counter_next = gap_counter + 1'b1;
    target = (cfg.edges == '0) ? irpd_pkg::COUNT_BITS'(1) : cfg.edges;
    emit   = (gap_counter_next >= target);

    addr_bits = bit_shifter_next[irpd_pkg::SHIFT_BITS-1:irpd_pkg::CMD_BITS];
    frame.address = '0;
    frame.command = '0;
    if (!leader_seen_next) begin
      frame.status = irpd_pkg::STATUS_NO_LEADER;
    end else if (bits_taken_next < irpd_pkg::FRAME_BITS) begin
      frame.status = irpd_pkg::STATUS_SHORT;
    end else begin
      frame.address = addr_bits;
      frame.command = bit_shifter_next[irpd_pkg::CMD_BITS-1:0];
      frame.status  = (addr_bits == cfg.exp_addr) ? irpd_pkg::STATUS_OK
                                                  : irpd_pkg::STATUS_ADDR_MISS;
    end
  end

  // State registers; a finished frame starts the next one from scratch.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_counter <= '0;
      leader_seen <= 1'b0;
      bits_taken  <= '0;
      bit_shifter <= '0;
    end else if (step) begin
      if (emit) begin
        gap_counter <= '0;
        leader_seen <= 1'b0;
        bits_taken  <= '0;
        bit_shifter <= '0;
      end else begin
        gap_counter <= gap_counter_next;
        leader_seen <= leader_seen_next;
        bits_taken  <= bits_taken_next;
        bit_shifter <= bit_shifter_next;
      end
    end
  end

endmodule

// ----- hw/rtl/ir_pulse_distance_frame_decoder.sv -----
// Pulse-distance IR frame decoder: gaps in, one frame verdict per frame out.
// A gap that ends a frame passes the input register, then the result register.
// Throughput: one gap per cycle, set by the single-step frame core between the
// input and result registers; a stalled result stops the flow and holds one gap.
// Reset (sync, rst high) loads register defaults, clears valid flags and core state.
// Depends on irpd_pkg, irpd_gap_if, irpd_frame_if and irpd_frame_core.
`timescale 1ns / 1ps

module ir_pulse_distance_frame_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [irpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [irpd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  irpd_gap_if.sink                           gap_in,
  irpd_frame_if.source                       frame_out
);

  irpd_pkg::cfg_t                cfg;
  logic                          in_valid;
  logic [irpd_pkg::GAP_BITS-1:0] in_gap;
  logic                          out_valid;
  irpd_pkg::frame_t              out_frame;
  logic                          advance;
  logic                          emit;
  irpd_pkg::frame_t              frame;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_thr <= irpd_pkg::LEADER_THR_RESET;
      cfg.one_thr    <= irpd_pkg::ONE_THR_RESET;
      cfg.exp_addr   <= irpd_pkg::ADDR_RESET;
      cfg.edges      <= irpd_pkg::EDGES_RESET;
    end else if (cfg_write) begin
      case (irpd_pkg::reg_idx_t'(cfg_index))
        irpd_pkg::REG_LEADER_THR: cfg.leader_thr <= cfg_data[irpd_pkg::THR_BITS-1:0];
        irpd_pkg::REG_ONE_THR:    cfg.one_thr    <= cfg_data[irpd_pkg::THR_BITS-1:0];
        irpd_pkg::REG_EXP_ADDR:   cfg.exp_addr   <= cfg_data[irpd_pkg::ADDR_BITS-1:0];
        irpd_pkg::REG_EDGES:      cfg.edges      <= cfg_data[irpd_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The held gap moves on whenever the result register is free or being emptied.
  assign advance      = in_valid && (!out_valid || frame_out.ready);
  assign gap_in.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (gap_in.ready) begin
      in_valid <= gap_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (gap_in.valid && gap_in.ready) begin
      in_gap <= gap_in.gap_us;
    end
  end

  irpd_frame_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .gap   (in_gap),
    .cfg   (cfg),
    .emit  (emit),
    .frame (frame)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (frame_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_frame <= frame;
    end
  end

  assign frame_out.valid        = out_valid;
  assign frame_out.frame_status = out_frame.status;
  assign frame_out.address_code = out_frame.address;
  assign frame_out.command_code = out_frame.command;

endmodule
